// ----- hw/rtl/wumm_pkg.sv -----
// ----------------------------------------------------------------------------
// wumm_pkg
// Shared constants and types for the windowed usage min/max/mean block.
// ----------------------------------------------------------------------------
package wumm_pkg;

  localparam int FIELD_W           = 16;  // width of every sample and result field
  localparam int CFG_W             = 7;   // width of the window length register
  localparam int NUM_CH            = 3;   // idle, user, kernel
  localparam int DEF_HISTORY_DEPTH = 64;
  localparam int DEF_FRACTION_BITS = 16;
  localparam int WINDOW_RESET      = 16;

  // per-cycle command to every cell of the sample chain
  typedef struct packed {
    logic push;    // shift toward the tail, new sample enters cell 0
    logic rotate;  // shift toward cell 0, cell 0 wraps to the tail
  } wumm_cell_ctl_t;

endpackage

// ----- hw/rtl/wumm_if.sv -----
// ----------------------------------------------------------------------------
// wumm_if
// Valid/ready channels for samples in and statistics out.
// ----------------------------------------------------------------------------
interface wumm_in_if import wumm_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] idle_sample;
  logic [FIELD_W-1:0] user_sample;
  logic [FIELD_W-1:0] kernel_sample;

  modport source (output valid, idle_sample, user_sample, kernel_sample, input ready);
  modport sink   (input valid, idle_sample, user_sample, kernel_sample, output ready);

endinterface

interface wumm_out_if import wumm_pkg::*; ();

  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] last_idle;
  logic [FIELD_W-1:0] last_user;
  logic [FIELD_W-1:0] last_kernel;
  logic [FIELD_W-1:0] mean_idle;
  logic [FIELD_W-1:0] mean_user;
  logic [FIELD_W-1:0] mean_kernel;
  logic [FIELD_W-1:0] min_idle;
  logic [FIELD_W-1:0] min_user;
  logic [FIELD_W-1:0] min_kernel;
  logic [FIELD_W-1:0] max_idle;
  logic [FIELD_W-1:0] max_user;
  logic [FIELD_W-1:0] max_kernel;

  modport source (output valid, last_idle, last_user, last_kernel,
                  mean_idle, mean_user, mean_kernel, min_idle, min_user, min_kernel,
                  max_idle, max_user, max_kernel, input ready);
  modport sink   (input valid, last_idle, last_user, last_kernel,
                  mean_idle, mean_user, mean_kernel, min_idle, min_user, min_kernel,
                  max_idle, max_user, max_kernel, output ready);

endinterface

// ----- hw/rtl/wumm_cell.sv -----
// ----------------------------------------------------------------------------
// wumm_cell
// One entry of the sample chain: holds one packed sample, takes its left
// neighbor on push and its right neighbor on rotate.
// ----------------------------------------------------------------------------
module wumm_cell import wumm_pkg::*; #(
  parameter int W = 3 * DEF_FRACTION_BITS
) (
  input  logic           clk,
  input  wumm_cell_ctl_t ctl,
  input  logic [W-1:0]   prev_data,
  input  logic [W-1:0]   next_data,
  output logic [W-1:0]   data
);

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      data <= prev_data;
    end else if (ctl.rotate) begin
      data <= next_data;
    end
  end

endmodule

// ----- hw/rtl/wumm_div.sv -----
// ----------------------------------------------------------------------------
// wumm_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wumm_div import wumm_pkg::*; #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 7
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic [NUM_W-1:0] quo,
  output logic             done
);

  localparam int CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W-1:0] rem_next;
  logic [NUM_W-1:0] quo_next;

  always_comb begin
    trial    = {rem, quo[NUM_W-1]};
    ge       = trial >= {1'b0, den_q};
    rem_next = ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
    quo_next = {quo[NUM_W-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
      if (cnt == CNT_W'(NUM_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo   <= num;
      rem   <= '0;
      den_q <= den;
    end else if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
    end
  end

endmodule

// ----- hw/rtl/windowed_usage_min_max_mean.sv -----
// ----------------------------------------------------------------------------
// windowed_usage_min_max_mean
// Sliding-window statistics over idle/user/kernel load fractions.
// ----------------------------------------------------------------------------
// Each accepted sample beat is pushed into a chain of HISTORY_DEPTH cells and
// one statistics beat follows: the sample itself and, per channel, the
// truncated mean, minimum and maximum over the last fill_count samples, where
// fill_count grows by one per sample up to the window length. For each sample
// the chain rotates once all the way round past the accumulators at cell 0,
// then three bit-serial dividers form the means. The next sample is taken as
// soon as the result sits in the output register. A write of window_length
// (0 reads as 1, values above HISTORY_DEPTH saturate) restarts the fill count;
// write it only while no sample is in flight.
// ----------------------------------------------------------------------------
module windowed_usage_min_max_mean import wumm_pkg::*; #(
  parameter int HISTORY_DEPTH = DEF_HISTORY_DEPTH,
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wr_data,
  wumm_in_if.sink          sample,
  wumm_out_if.source       stats
);

  localparam int VAL_W   = (FRACTION_BITS < FIELD_W) ? FRACTION_BITS : FIELD_W;
  localparam int CELL_W  = NUM_CH * VAL_W;
  localparam int CW      = $clog2(HISTORY_DEPTH + 1);
  localparam int IDX_W   = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int SUM_W   = VAL_W + CW;
  localparam int WIN_RST = (WINDOW_RESET > HISTORY_DEPTH) ? HISTORY_DEPTH : WINDOW_RESET;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_START = 2'd2;
  localparam logic [1:0] ST_DIV   = 2'd3;

  logic [1:0]        state;
  logic [CW-1:0]     window;
  logic [CW-1:0]     window_next;
  logic [CW-1:0]     fill;
  logic [IDX_W-1:0]  step;
  logic              accept;
  logic              finish;
  wumm_cell_ctl_t    ctl;
  logic [CELL_W-1:0] new_cell;
  logic [CELL_W-1:0] cell_q [HISTORY_DEPTH];
  logic [CELL_W-1:0] last;
  logic [SUM_W-1:0]  sum  [NUM_CH];
  logic [VAL_W-1:0]  mn   [NUM_CH];
  logic [VAL_W-1:0]  mx   [NUM_CH];
  logic [SUM_W-1:0]  quo  [NUM_CH];
  logic [NUM_CH-1:0] div_done;
  logic              div_start;

  assign sample.ready = (state == ST_IDLE) && !rst;
  assign accept       = sample.valid && sample.ready;
  assign finish       = (state == ST_DIV) && (&div_done) && (!stats.valid || stats.ready);
  assign div_start    = (state == ST_START);
  assign ctl.push     = accept;
  assign ctl.rotate   = (state == ST_SCAN);
  assign new_cell     = {sample.kernel_sample[VAL_W-1:0], sample.user_sample[VAL_W-1:0],
                         sample.idle_sample[VAL_W-1:0]};

  always_comb begin
    if (cfg_wr_data == '0) begin
      window_next = CW'(1);
    end else if (int'(cfg_wr_data) > HISTORY_DEPTH) begin
      window_next = CW'(HISTORY_DEPTH);
    end else begin
      window_next = CW'(cfg_wr_data);
    end
  end

  // sample chain: push shifts toward the tail, rotate brings entry k to cell 0 at step k
  for (genvar i = 0; i < HISTORY_DEPTH; i++) begin : g_cell
    wumm_cell #(.W(CELL_W)) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_data ((i == 0) ? new_cell : cell_q[(i + HISTORY_DEPTH - 1) % HISTORY_DEPTH]),
      .next_data (cell_q[(i + 1) % HISTORY_DEPTH]),
      .data      (cell_q[i])
    );
  end

  for (genvar c = 0; c < NUM_CH; c++) begin : g_div
    wumm_div #(.NUM_W(SUM_W), .DEN_W(CW)) u_div (
      .clk   (clk),
      .rst   (rst),
      .start (div_start),
      .num   (sum[c]),
      .den   (fill),
      .quo   (quo[c]),
      .done  (div_done[c])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      window       <= CW'(WIN_RST);
      fill         <= '0;
      step         <= '0;
      stats.valid  <= 1'b0;
    end else begin
      if (finish) begin
        stats.valid <= 1'b1;
      end else if (stats.valid && stats.ready) begin
        stats.valid <= 1'b0;
      end
      if (cfg_wr_en) begin
        window <= window_next;
        fill   <= '0;
      end else if (accept && fill < window) begin
        fill <= fill + 1'b1;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            step  <= '0;
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          step <= step + 1'b1;
          if (step == IDX_W'(HISTORY_DEPTH - 1)) begin
            state <= ST_START;
          end
        end
        ST_START: begin
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (finish) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // accumulators watch cell 0 while the chain rotates
  always_ff @(posedge clk) begin
    if (accept) begin
      last <= new_cell;
      for (int c = 0; c < NUM_CH; c++) begin
        sum[c] <= '0;
        mn[c]  <= '1;
        mx[c]  <= '0;
      end
    end else if (state == ST_SCAN && fill > CW'(step)) begin
      for (int c = 0; c < NUM_CH; c++) begin
        sum[c] <= sum[c] + SUM_W'(cell_q[0][c*VAL_W +: VAL_W]);
        if (cell_q[0][c*VAL_W +: VAL_W] < mn[c]) begin
          mn[c] <= cell_q[0][c*VAL_W +: VAL_W];
        end
        if (cell_q[0][c*VAL_W +: VAL_W] > mx[c]) begin
          mx[c] <= cell_q[0][c*VAL_W +: VAL_W];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (finish) begin
      stats.last_idle   <= FIELD_W'(last[0*VAL_W +: VAL_W]);
      stats.last_user   <= FIELD_W'(last[1*VAL_W +: VAL_W]);
      stats.last_kernel <= FIELD_W'(last[2*VAL_W +: VAL_W]);
      stats.mean_idle   <= FIELD_W'(quo[0][VAL_W-1:0]);
      stats.mean_user   <= FIELD_W'(quo[1][VAL_W-1:0]);
      stats.mean_kernel <= FIELD_W'(quo[2][VAL_W-1:0]);
      stats.min_idle    <= FIELD_W'(mn[0]);
      stats.min_user    <= FIELD_W'(mn[1]);
      stats.min_kernel  <= FIELD_W'(mn[2]);
      stats.max_idle    <= FIELD_W'(mx[0]);
      stats.max_user    <= FIELD_W'(mx[1]);
      stats.max_kernel  <= FIELD_W'(mx[2]);
    end
  end

`ifndef SYNTHESIS
  a_fill_in_window: assert property (@(posedge clk) disable iff (rst)
    fill <= window)
    else $error("fill count exceeds window length");

  a_window_range: assert property (@(posedge clk) disable iff (rst)
    window != '0 && int'(window) <= HISTORY_DEPTH)
    else $error("window length out of range");

  a_accept_starts_scan: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SCAN && step == '0)
    else $error("accepted sample did not start a scan");

  a_result_after_divide: assert property (@(posedge clk) disable iff (rst)
    $rose(stats.valid) |-> $past(state) == ST_DIV && $past(div_done[0]))
    else $error("result raised without finished division");
`endif

endmodule
